>>> design/hrhp_pkg.sv
package hrhp_pkg;

  typedef enum logic [3:0] {
    ST_VERSION   = 4'd0,
    ST_SP1       = 4'd1,
    ST_STATUS    = 4'd2,
    ST_SP2       = 4'd3,
    ST_REASON    = 4'd4,
    ST_REASON_LF = 4'd5,
    ST_LINE      = 4'd6,
    ST_NAME      = 4'd7,
    ST_OWS       = 4'd8,
    ST_VALUE     = 4'd9,
    ST_VALUE_LF  = 4'd10,
    ST_FINAL_LF  = 4'd11,
    ST_DONE      = 4'd12
  } stage_t;

  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_VERSION = 3'd1;
  localparam logic [2:0] CLS_STATUS  = 3'd2;
  localparam logic [2:0] CLS_REASON  = 3'd3;
  localparam logic [2:0] CLS_NAME    = 3'd4;
  localparam logic [2:0] CLS_VALUE   = 3'd5;
  localparam logic [2:0] CLS_HEAD    = 3'd6;
  localparam logic [2:0] CLS_AFTER   = 3'd7;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_CLOSE_VERSION = 4'd1;
  localparam logic [3:0] ERR_PROTOCOL      = 4'd2;
  localparam logic [3:0] ERR_CLOSE_DELIM   = 4'd3;
  localparam logic [3:0] ERR_SPACE         = 4'd4;
  localparam logic [3:0] ERR_CLOSE_STATUS  = 4'd5;
  localparam logic [3:0] ERR_STATUS        = 4'd6;
  localparam logic [3:0] ERR_CLOSE_REASON  = 4'd7;
  localparam logic [3:0] ERR_REASON        = 4'd8;
  localparam logic [3:0] ERR_LF            = 4'd9;
  localparam logic [3:0] ERR_CLOSE_NAME    = 4'd10;
  localparam logic [3:0] ERR_NAME          = 4'd11;
  localparam logic [3:0] ERR_CLOSE_OWS     = 4'd12;
  localparam logic [3:0] ERR_CLOSE_VALUE   = 4'd13;
  localparam logic [3:0] ERR_VALUE         = 4'd14;
  localparam logic [3:0] ERR_FIELD_LF      = 4'd15;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Classified beat handed from the front to the parser
  typedef struct packed {
    logic       restart;
    logic       close;
    logic [7:0] data;
    logic       digit;
    logic       status_lead;
    logic       tchar;
    logic       vchar_obs;
    logic       sp;
    logic       tab;
    logic       cr;
    logic       lf;
    logic       colon;
    logic       dot;
  } beat_t;

  function automatic logic [7:0] proto_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      default: c = 8'h2F;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] close_error(input stage_t st);
    logic [3:0] e;
    unique case (st)
      ST_VERSION:  e = ERR_CLOSE_VERSION;
      ST_STATUS:   e = ERR_CLOSE_STATUS;
      ST_REASON:   e = ERR_CLOSE_REASON;
      ST_NAME:     e = ERR_CLOSE_NAME;
      ST_OWS:      e = ERR_CLOSE_OWS;
      ST_VALUE:    e = ERR_CLOSE_VALUE;
      ST_VALUE_LF: e = ERR_CLOSE_OWS;
      default:     e = ERR_CLOSE_DELIM;
    endcase
    return e;
  endfunction

endpackage

>>> design/http_response_head_parser.sv
// Checks an HTTP/1.1 response head one received byte per beat and returns one
// result beat for every input beat: the byte echoed with its class, the latched
// error code, the status code and version digits gathered so far, and the
// version and final-LF flags. Input beats pass through a character classifier
// into a two-entry queue; the parser takes one beat a cycle from the queue into
// a registered output, so with no stall on the output a beat goes through every
// cycle and its result beat is presented from the output register once the input
// beat has passed through the queue. The output stage and the queue stall
// independently, and the input is stalled only when the queue is full.
module http_response_head_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] byte_class,
  output logic [7:0] out_byte,
  output logic [3:0] error_code,
  output logic [9:0] status_code,
  output logic [3:0] version_major,
  output logic [3:0] version_minor,
  output logic       version_not_11,
  output logic       final_lf_missing,
  output logic       value_end
);
  import hrhp_pkg::*;

  beat_t in_beat;
  beat_t q_beat;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  assign in_stall = q_full;

  hrhp_front u_front (
    .action    (action),
    .data_byte (data_byte),
    .beat      (in_beat)
  );

  hrhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_beat (in_beat),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_beat  (q_beat)
  );

  hrhp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .beat             (q_beat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_class       (byte_class),
    .out_byte         (out_byte),
    .error_code       (error_code),
    .status_code      (status_code),
    .version_major    (version_major),
    .version_minor    (version_minor),
    .version_not_11   (version_not_11),
    .final_lf_missing (final_lf_missing),
    .value_end        (value_end)
  );

endmodule

>>> design/hrhp_front.sv
module hrhp_front (
  input  logic [1:0]     action,
  input  logic [7:0]     data_byte,
  output hrhp_pkg::beat_t beat
);
  import hrhp_pkg::*;

  logic [7:0] b;
  logic       alpha;
  logic       punct;

  assign b = data_byte;

  always_comb begin
    alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    case (b)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: punct = 1'b1;
      default: punct = 1'b0;
    endcase

    beat.restart     = action[1];
    beat.close       = (action == ACT_CLOSE);
    beat.data        = b;
    beat.digit       = (b >= 8'h30 && b <= 8'h39);
    beat.status_lead = (b >= 8'h31 && b <= 8'h35);
    beat.tchar       = beat.digit || alpha || punct;
    beat.vchar_obs   = (b >= 8'h21 && b <= 8'h7E) || b[7];
    beat.sp          = (b == CH_SP);
    beat.tab         = (b == CH_TAB);
    beat.cr          = (b == CH_CR);
    beat.lf          = (b == CH_LF);
    beat.colon       = (b == CH_COLON);
    beat.dot         = (b == CH_DOT);
  end

endmodule

>>> design/hrhp_queue.sv
module hrhp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hrhp_pkg::beat_t push_beat,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hrhp_pkg::beat_t pop_beat
);
  import hrhp_pkg::*;

  beat_t      entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_beat  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_beat;
  end

endmodule

>>> design/hrhp_back.sv
module hrhp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  hrhp_pkg::beat_t beat,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      byte_class,
  output logic [7:0]      out_byte,
  output logic [3:0]      error_code,
  output logic [9:0]      status_code,
  output logic [3:0]      version_major,
  output logic [3:0]      version_minor,
  output logic            version_not_11,
  output logic            final_lf_missing,
  output logic            value_end
);
  import hrhp_pkg::*;

  stage_t     stage, stage_cur, stage_next;
  logic [2:0] pos, pos_cur, pos_next;
  logic [9:0] acc, acc_cur, acc_next;
  logic [3:0] major, major_cur, major_next;
  logic [3:0] minor, minor_cur, minor_next;
  logic [3:0] err, err_cur, err_next;
  logic [1:0] flags, flags_cur, flags_next;
  logic [2:0] cls;
  logic       vend;
  logic [9:0] acc_x10;

  // Take a beat whenever the output register is free or being drained
  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    // A restart beat sees the post-reset state
    stage_cur = beat.restart ? ST_VERSION : stage;
    pos_cur   = beat.restart ? 3'd0 : pos;
    acc_cur   = beat.restart ? 10'd0 : acc;
    major_cur = beat.restart ? 4'd0 : major;
    minor_cur = beat.restart ? 4'd0 : minor;
    err_cur   = beat.restart ? ERR_NONE : err;
    flags_cur = beat.restart ? 2'd0 : flags;

    stage_next = stage_cur;
    pos_next   = pos_cur;
    acc_next   = acc_cur;
    major_next = major_cur;
    minor_next = minor_cur;
    err_next   = err_cur;
    flags_next = flags_cur;
    cls        = CLS_NONE;
    vend       = 1'b0;
    acc_x10    = {acc_cur[6:0], 3'b000} + {acc_cur[8:0], 1'b0};

    if (beat.close) begin
      if (err_cur == ERR_NONE) begin
        if (stage_cur == ST_FINAL_LF) begin
          flags_next[1] = 1'b1;
          stage_next    = ST_DONE;
          cls           = CLS_HEAD;
        end else if (stage_cur != ST_DONE) begin
          err_next = close_error(stage_cur);
        end
      end
    end else if (err_cur == ERR_NONE) begin
      unique case (stage_cur)
        ST_VERSION: begin
          if (pos_cur < 3'd5) begin
            if (beat.data != proto_char(pos_cur)) err_next = ERR_PROTOCOL;
            else begin
              cls      = CLS_VERSION;
              pos_next = pos_cur + 3'd1;
            end
          end else if (pos_cur == 3'd5) begin
            if (!beat.digit) err_next = ERR_PROTOCOL;
            else begin
              cls        = CLS_VERSION;
              major_next = beat.data[3:0];
              pos_next   = pos_cur + 3'd1;
            end
          end else if (pos_cur == 3'd6) begin
            if (!beat.dot) err_next = ERR_PROTOCOL;
            else begin
              cls      = CLS_VERSION;
              pos_next = pos_cur + 3'd1;
            end
          end else begin
            if (!beat.digit) err_next = ERR_PROTOCOL;
            else begin
              cls        = CLS_VERSION;
              minor_next = beat.data[3:0];
              if (major_cur != 4'd1 || beat.data[3:0] != 4'd1) flags_next[0] = 1'b1;
              stage_next = ST_SP1;
              pos_next   = 3'd0;
            end
          end
        end
        ST_SP1, ST_SP2: begin
          if (!beat.sp) err_next = ERR_SPACE;
          else stage_next = (stage_cur == ST_SP1) ? ST_STATUS : ST_REASON;
        end
        ST_STATUS: begin
          if ((pos_cur == 3'd0) ? !beat.status_lead : !beat.digit) begin
            err_next = ERR_STATUS;
          end else begin
            cls      = CLS_STATUS;
            acc_next = acc_x10 + {6'd0, beat.data[3:0]};
            if (pos_cur >= 3'd2) begin
              pos_next   = 3'd0;
              stage_next = ST_SP2;
            end else begin
              pos_next = pos_cur + 3'd1;
            end
          end
        end
        ST_REASON: begin
          if (beat.cr) stage_next = ST_REASON_LF;
          else if (beat.tab || beat.sp || beat.vchar_obs) cls = CLS_REASON;
          else err_next = ERR_REASON;
        end
        ST_REASON_LF: begin
          if (!beat.lf) err_next = ERR_LF;
          else stage_next = ST_LINE;
        end
        ST_LINE: begin
          if (beat.cr) stage_next = ST_FINAL_LF;
          else if (!beat.tchar) err_next = ERR_NAME;
          else begin
            stage_next = ST_NAME;
            cls        = CLS_NAME;
          end
        end
        ST_NAME: begin
          if (beat.colon) stage_next = ST_OWS;
          else if (!beat.tchar) err_next = ERR_NAME;
          else cls = CLS_NAME;
        end
        ST_OWS: begin
          if (beat.sp || beat.tab) cls = CLS_NONE;
          else if (beat.cr) stage_next = ST_VALUE_LF;
          else if (!beat.vchar_obs) err_next = ERR_VALUE;
          else begin
            stage_next = ST_VALUE;
            cls        = CLS_VALUE;
          end
        end
        ST_VALUE: begin
          if (beat.cr) stage_next = ST_VALUE_LF;
          else if (beat.sp || beat.tab || beat.vchar_obs) cls = CLS_VALUE;
          else err_next = ERR_VALUE;
        end
        ST_VALUE_LF: begin
          if (!beat.lf) err_next = ERR_FIELD_LF;
          else begin
            vend       = 1'b1;
            stage_next = ST_LINE;
          end
        end
        ST_FINAL_LF: begin
          if (!beat.lf) flags_next[1] = 1'b1;
          stage_next = ST_DONE;
          cls        = CLS_HEAD;
        end
        default: cls = CLS_AFTER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_VERSION;
      pos       <= 3'd0;
      acc       <= 10'd0;
      major     <= 4'd0;
      minor     <= 4'd0;
      err       <= ERR_NONE;
      flags     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        stage     <= stage_next;
        pos       <= pos_next;
        acc       <= acc_next;
        major     <= major_next;
        minor     <= minor_next;
        err       <= err_next;
        flags     <= flags_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result beat payload; holds while stalled
  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_class       <= cls;
      out_byte         <= beat.close ? 8'd0 : beat.data;
      error_code       <= err_next;
      status_code      <= acc_next;
      version_major    <= major_next;
      version_minor    <= minor_next;
      version_not_11   <= flags_next[0];
      final_lf_missing <= flags_next[1];
      value_end        <= vend;
    end
  end

endmodule

>>> dv/http_response_head_parser_test.sv
module http_response_head_parser_test;
  import hrhp_pkg::*;

  localparam logic [1:0] ACT_RESTART     = 2'd2;
  localparam logic [1:0] ACT_RESTART_ALT = 2'd3;

  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_STATUS_LO = 8'h31;
  localparam logic [7:0] CH_STATUS_HI = 8'h35;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [39:0] HEAD_TAG    = 40'h48_54_54_50_2F;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] b;
    logic [4:0] gap;
  } rx_beat_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] data;
    logic [3:0] err;
    logic [9:0] status;
    logic [3:0] major;
    logic [3:0] minor;
    logic       not11;
    logic       lf_missing;
    logic       vend;
  } head_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_DATA;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] byte_class;
  logic [7:0] out_byte;
  logic [3:0] error_code;
  logic [9:0] status_code;
  logic [3:0] version_major;
  logic [3:0] version_minor;
  logic       version_not_11;
  logic       final_lf_missing;
  logic       value_end;

  http_response_head_parser dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_class       (byte_class),
    .out_byte         (out_byte),
    .error_code       (error_code),
    .status_code      (status_code),
    .version_major    (version_major),
    .version_minor    (version_minor),
    .version_not_11   (version_not_11),
    .final_lf_missing (final_lf_missing),
    .value_end        (value_end)
  );

  rx_beat_t     pending_beats[$];
  head_result_t pending_results[$];
  logic [7:0]   head_bytes[$];
  rx_beat_t     next_beat;
  head_result_t want;

  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned send_wait = 0;
  int unsigned send_gap_max = 16;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  logic        out_idle_on = 1'b1;

  // Parser state as the checker sees it
  stage_t     p_stage;
  logic [2:0] p_pos;
  logic [9:0] p_status;
  logic [3:0] p_major;
  logic [3:0] p_minor;
  logic [3:0] p_err;
  logic [1:0] p_flags;

  function automatic logic is_tchar(input logic [7:0] c);
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", "|", "~", CH_BACKTICK:
        return 1'b1;
      default:
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endcase
  endfunction

  function automatic logic is_vchar_obs(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h7E) || c >= 8'h80;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    head_bytes.insert(head_bytes.size(), c);
  endfunction

  function automatic void expect_result(input head_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void clear_parse();
    p_stage  = ST_VERSION;
    p_pos    = '0;
    p_status = '0;
    p_major  = '0;
    p_minor  = '0;
    p_err    = ERR_NONE;
    p_flags  = '0;
  endfunction

  function automatic head_result_t predict_beat(input logic [1:0] act, input logic [7:0] b);
    head_result_t r;
    logic [2:0]   cls;
    logic         vend;
    cls  = CLS_NONE;
    vend = 1'b0;
    if (act[1])
      clear_parse();
    if (act == ACT_CLOSE) begin
      if (p_err == ERR_NONE) begin
        if (p_stage == ST_FINAL_LF) begin
          p_flags[1] = 1'b1;
          p_stage    = ST_DONE;
          cls        = CLS_HEAD;
        end else if (p_stage != ST_DONE) begin
          case (p_stage)
            ST_VERSION:          p_err = ERR_CLOSE_VERSION;
            ST_STATUS:           p_err = ERR_CLOSE_STATUS;
            ST_REASON:           p_err = ERR_CLOSE_REASON;
            ST_NAME:             p_err = ERR_CLOSE_NAME;
            ST_OWS, ST_VALUE_LF: p_err = ERR_CLOSE_OWS;
            ST_VALUE:            p_err = ERR_CLOSE_VALUE;
            default:             p_err = ERR_CLOSE_DELIM;
          endcase
        end
      end
    end else if (p_err == ERR_NONE) begin
      case (p_stage)
        ST_VERSION: begin
          if (p_pos < 3'd5) begin
            if (b != HEAD_TAG[39 - 8 * p_pos -: 8]) p_err = ERR_PROTOCOL;
          end else if (p_pos == 3'd6) begin
            if (b != CH_DOT) p_err = ERR_PROTOCOL;
          end else if (!is_digit(b)) begin
            p_err = ERR_PROTOCOL;
          end else if (p_pos == 3'd5) begin
            p_major = b[3:0];
          end else begin
            p_minor = b[3:0];
            if (p_major != 4'd1 || p_minor != 4'd1)
              p_flags[0] = 1'b1;
          end
          if (p_err == ERR_NONE) begin
            cls = CLS_VERSION;
            if (p_pos == 3'd7) begin
              p_stage = ST_SP1;
              p_pos   = '0;
            end else begin
              p_pos = p_pos + 3'd1;
            end
          end
        end
        ST_SP1, ST_SP2: begin
          if (b != CH_SP) p_err = ERR_SPACE;
          else p_stage = (p_stage == ST_SP1) ? ST_STATUS : ST_REASON;
        end
        ST_STATUS: begin
          if (p_pos == 3'd0 ? (b < CH_STATUS_LO || b > CH_STATUS_HI) : !is_digit(b)) begin
            p_err = ERR_STATUS;
          end else begin
            p_status = p_status * 10'd10 + {6'd0, b[3:0]};
            cls      = CLS_STATUS;
            if (p_pos == 3'd2) begin
              p_pos   = '0;
              p_stage = ST_SP2;
            end else begin
              p_pos = p_pos + 3'd1;
            end
          end
        end
        ST_REASON: begin
          if (b == CH_CR) p_stage = ST_REASON_LF;
          else if (b == CH_TAB || b == CH_SP || is_vchar_obs(b)) cls = CLS_REASON;
          else p_err = ERR_REASON;
        end
        ST_REASON_LF: begin
          if (b != CH_LF) p_err = ERR_LF;
          else p_stage = ST_LINE;
        end
        ST_LINE: begin
          if (b == CH_CR) begin
            p_stage = ST_FINAL_LF;
          end else if (!is_tchar(b)) begin
            p_err = ERR_NAME;
          end else begin
            p_stage = ST_NAME;
            cls     = CLS_NAME;
          end
        end
        ST_NAME: begin
          if (b == CH_COLON) p_stage = ST_OWS;
          else if (!is_tchar(b)) p_err = ERR_NAME;
          else cls = CLS_NAME;
        end
        ST_OWS: begin
          // a CR here closes an empty value
          if (b == CH_CR) begin
            p_stage = ST_VALUE_LF;
          end else if (b != CH_SP && b != CH_TAB) begin
            if (!is_vchar_obs(b)) begin
              p_err = ERR_VALUE;
            end else begin
              p_stage = ST_VALUE;
              cls     = CLS_VALUE;
            end
          end
        end
        ST_VALUE: begin
          if (b == CH_CR) p_stage = ST_VALUE_LF;
          else if (b == CH_SP || b == CH_TAB || is_vchar_obs(b)) cls = CLS_VALUE;
          else p_err = ERR_VALUE;
        end
        ST_VALUE_LF: begin
          if (b != CH_LF) begin
            p_err = ERR_FIELD_LF;
          end else begin
            vend    = 1'b1;
            p_stage = ST_LINE;
          end
        end
        ST_FINAL_LF: begin
          if (b != CH_LF) p_flags[1] = 1'b1;
          p_stage = ST_DONE;
          cls     = CLS_HEAD;
        end
        default: cls = CLS_AFTER;
      endcase
    end
    r.cls        = cls;
    r.data       = (act == ACT_CLOSE) ? 8'h00 : b;
    r.err        = p_err;
    r.status     = p_status;
    r.major      = p_major;
    r.minor      = p_minor;
    r.not11      = p_flags[0];
    r.lf_missing = p_flags[1];
    r.vend       = vend;
    return r;
  endfunction

  task automatic push_beat(input logic [1:0] act, input logic [7:0] b);
    rx_beat_t t;
    t.act = act;
    t.b   = b;
    t.gap = (send_gap_max == 0) ? 5'd0 : 5'($urandom_range(16, 0));
    pending_beats.insert(pending_beats.size(), t);
    beats_queued++;
  endtask

  // Build one response head with random content, then send it clean, with one byte
  // spoilt, cut short by a close, or replace it with noise.
  task automatic push_head();
    logic [7:0]  c;
    logic [1:0]  first_act;
    int unsigned i, j, len, n_fields, mode, cut;
    head_bytes.delete();
    for (i = 0; i < 5; i++)
      add_byte(HEAD_TAG[39 - 8 * i -: 8]);
    if ($urandom_range(4, 0) != 0) begin
      add_byte(CH_ZERO + 8'd1);
      add_byte(CH_DOT);
      add_byte(CH_ZERO + 8'd1);
    end else begin
      add_byte(CH_ZERO + 8'($urandom_range(9, 0)));
      add_byte(CH_DOT);
      add_byte(CH_ZERO + 8'($urandom_range(9, 0)));
    end
    add_byte(CH_SP);
    add_byte(CH_ZERO + 8'($urandom_range(5, 1)));
    add_byte(CH_ZERO + 8'($urandom_range(9, 0)));
    add_byte(CH_ZERO + 8'($urandom_range(9, 0)));
    add_byte(CH_SP);
    len = $urandom_range(4, 0);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(9, 0))
        0:       c = CH_TAB;
        1:       c = CH_SP;
        default: do c = 8'($urandom_range(255, 33)); while (!is_vchar_obs(c));
      endcase
      add_byte(c);
    end
    add_byte(CH_CR);
    add_byte(CH_LF);
    n_fields = $urandom_range(3, 0);
    for (i = 0; i < n_fields; i++) begin
      len = $urandom_range(4, 1);
      for (j = 0; j < len; j++) begin
        do c = 8'($urandom_range(126, 33)); while (!is_tchar(c));
        add_byte(c);
      end
      add_byte(CH_COLON);
      len = $urandom_range(2, 0);
      for (j = 0; j < len; j++)
        add_byte($urandom_range(1, 0) ? CH_SP : CH_TAB);
      len = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(4, 1);
      for (j = 0; j < len; j++) begin
        if (j != 0 && $urandom_range(6, 0) == 0)
          c = $urandom_range(1, 0) ? CH_SP : CH_TAB;
        else
          do c = 8'($urandom_range(255, 33)); while (!is_vchar_obs(c));
        add_byte(c);
      end
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    add_byte(CH_CR);
    add_byte(($urandom_range(6, 0) == 0) ? 8'($urandom_range(255, 0)) : CH_LF);
    len = $urandom_range(3, 0);
    for (i = 0; i < len; i++)
      add_byte(8'($urandom_range(255, 0)));

    send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 16;
    mode = $urandom_range(19, 0);
    cut  = $urandom_range(head_bytes.size(), 0);
    if (mode >= 8 && mode <= 12)
      head_bytes[$urandom_range(head_bytes.size() - 1, 0)] = 8'($urandom_range(255, 0));
    if (mode == 19) begin
      for (i = 0; i < 8; i++)
        push_beat(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
    end else begin
      case ($urandom_range(9, 0))
        0:       first_act = ACT_DATA;
        1, 2, 3: first_act = ACT_RESTART_ALT;
        default: first_act = ACT_RESTART;
      endcase
      for (i = 0; i < head_bytes.size(); i++) begin
        if (mode >= 13 && i == cut)
          break;
        push_beat((i == 0) ? first_act : ACT_DATA, head_bytes[i]);
      end
      if (mode >= 13 || (mode < 8 && $urandom_range(2, 0) == 0))
        push_beat(ACT_CLOSE, 8'($urandom_range(255, 0)));
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample handshakes, predict on each input beat, check each output beat
  always @(posedge clk) begin
    in_took  <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
    if (rst) begin
      clear_parse();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("output beat with nothing predicted: class %0d byte %0h", byte_class, out_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_class", want.cls, byte_class);
          check_field("out_byte", want.data, out_byte);
          check_field("error_code", want.err, error_code);
          check_field("status_code", want.status, status_code);
          check_field("version_major", want.major, version_major);
          check_field("version_minor", want.minor, version_minor);
          check_field("version_not_11", want.not11, version_not_11);
          check_field("final_lf_missing", want.lf_missing, final_lf_missing);
          check_field("value_end", want.vend, value_end);
        end
      end
      if (in_valid && !in_stall) begin
        expect_result(predict_beat(action, data_byte));
        beats_taken++;
      end
    end
  end

  // Sender: hold a stalled beat, otherwise wait out the gap and offer the next
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_wait < pending_beats[0].gap) begin
        send_wait++;
        in_valid <= 1'b0;
      end else begin
        next_beat = pending_beats.pop_front();
        send_wait = 0;
        action    <= next_beat.act;
        data_byte <= next_beat.b;
        in_valid  <= 1'b1;
      end
    end
  end

  // Receiver: random stall after each beat while stalls are enabled, two long hold-offs to back the block up
  always @(negedge clk) begin
    if (out_took) begin
      results_seen++;
      if (results_seen % 64 == 0)
        out_idle_on = ($urandom_range(3, 0) != 0);
      if (results_seen == 150 || results_seen == 450)
        hold_left = 200;
      out_wait = out_idle_on ? $urandom_range(16, 0) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    string       s;
    int unsigned i;
    // version 9.0, extreme status, obs-text and tab in the reason, then an empty name
    send_gap_max = 16;
    push_beat(ACT_RESTART_ALT, HEAD_TAG[39 -: 8]);
    s = "TTP/9.0 599 ";
    for (i = 0; i < s.len(); i++)
      push_beat(ACT_DATA, s[i]);
    push_beat(ACT_DATA, 8'hFF);
    push_beat(ACT_DATA, CH_TAB);
    push_beat(ACT_DATA, CH_CR);
    push_beat(ACT_DATA, CH_LF);
    push_beat(ACT_DATA, CH_COLON);
    // bytes and a close once an error is latched, then restarts that clear it
    push_beat(ACT_DATA, 8'h00);
    push_beat(ACT_CLOSE, 8'hFF);
    push_beat(ACT_RESTART, 8'h00);
    push_beat(ACT_DATA, 8'hFF);
    push_beat(ACT_RESTART, HEAD_TAG[39 -: 8]);
    push_beat(ACT_CLOSE, 8'hFF);
    while (beats_queued < 600)
      push_head();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (beats_taken != beats_queued)
      @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/hrhp_pkg.sv
design/hrhp_front.sv
design/hrhp_queue.sv
design/hrhp_back.sv
design/http_response_head_parser.sv
dv/http_response_head_parser_test.sv
